// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants for the indexed double-ended queue.
// Holds operation and status codes, controller states and the command
// and status structs that join the controller to the datapath.
package deq_pkg;

    // Default ring depth in words.
    localparam int DEPTH_DEFAULT = 256;

    // Fixed field widths of the stream words.
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 9;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 8;

    // Operation codes carried on the slave tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_WRITE_AT   = 3'd5
    } t_op;

    // Result status codes carried on the master tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-port RAM with a registered read port.
// Stand-alone; width and depth come from its parameters.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One address per cycle, for a write, a registered read or both.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller state machine of the indexed double-ended queue.
// Uses deq_pkg for states and the command and status structs.
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = deq_pkg::S_EXEC;
                end
            end
            deq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = deq_pkg::S_EMIT;
            end
            deq_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/deq_dp.sv =====
// Datapath of the indexed double-ended queue: item registers, ring
// pointers, slot arithmetic, the word store and the output register.
// Uses deq_pkg and instantiates deq_ram.
module deq_dp #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  deq_pkg::t_cmd                   i_cmd,
    output deq_pkg::t_sts                   o_sts,
    input  logic [deq_pkg::OP_W-1:0]        i_op,
    input  logic [deq_pkg::VALUE_W-1:0]     i_value,
    input  logic [deq_pkg::POS_W-1:0]       i_position,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [deq_pkg::VALUE_W-1:0]     o_data,
    output logic [deq_pkg::STAT_W-1:0]      o_status,
    output logic [deq_pkg::OCC_W-1:0]       o_occupancy
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PXW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
    localparam int OXW = (CW > deq_pkg::OCC_W) ? CW : deq_pkg::OCC_W;

    // Item registers, loaded on accept.
    logic [deq_pkg::OP_W-1:0]    r_op;
    logic [deq_pkg::VALUE_W-1:0] r_value;
    logic [deq_pkg::POS_W-1:0]   r_pos;

    // Ring state.
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Result of the executed item.
    deq_pkg::t_status r_status, n_status;
    logic             r_use_rd, n_use_rd;

    // Output register.
    logic                        r_m_tvalid;
    logic [deq_pkg::VALUE_W-1:0] r_m_data;
    logic [deq_pkg::STAT_W-1:0]  r_m_status;
    logic [deq_pkg::OCC_W-1:0]   r_m_occ;

    // Store access.
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_addr;
    logic [deq_pkg::VALUE_W-1:0] ram_rdata;

    // Slot arithmetic.
    logic          is_full, is_empty, pos_ok;
    logic [AW-1:0] offset, slot, front_dec;
    logic [AW:0]   slot_sum;
    logic [OXW-1:0] count_wide;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_ok   = (PXW'(r_pos) < PXW'(r_count));

    // Offset from the front for the current operation.
    always_comb begin
        case (r_op) inside
            deq_pkg::OP_PUSH_BACK:                     offset = r_count[AW-1:0];
            deq_pkg::OP_POP_BACK:                      offset = AW'(r_count - 1'b1);
            deq_pkg::OP_READ_AT, deq_pkg::OP_WRITE_AT: offset = AW'(r_pos);
            default:                                   offset = '0;
        endcase
    end

    // Ring index: sum stays below twice the depth, so one subtract wraps it.
    assign slot_sum  = {1'b0, r_front} + {1'b0, offset};
    assign slot      = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                    : slot_sum[AW-1:0];
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : AW'(r_front - 1'b1);

    // Execute step: checks, pointer updates and the store access.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        n_use_rd = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = slot;
        case (r_op)
            deq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = front_dec;
                    n_front  = front_dec;
                    n_count  = r_count + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = deq_pkg::ST_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re   = 1'b1;
                    n_use_rd = 1'b1;
                    n_front  = (r_front == AW'(DEPTH - 1)) ? '0 : AW'(r_front + 1'b1);
                    n_count  = r_count - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = deq_pkg::ST_EMPTY;
                end else begin
                    ram_re   = 1'b1;
                    n_use_rd = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            deq_pkg::OP_READ_AT: begin
                if (!pos_ok) begin
                    n_status = deq_pkg::ST_RANGE;
                end else begin
                    ram_re   = 1'b1;
                    n_use_rd = 1'b1;
                end
            end
            deq_pkg::OP_WRITE_AT: begin
                if (!pos_ok) begin
                    n_status = deq_pkg::ST_RANGE;
                end else begin
                    ram_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!i_cmd.exec) begin
            n_front = r_front;
            n_count = r_count;
            ram_we  = 1'b0;
            ram_re  = 1'b0;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    // Ring pointers and the pending result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
    end

    // Output register; the read word is already in the store's register.
    assign count_wide = OXW'(r_count);
    assign o_sts.out_free = !r_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data   <= r_use_rd ? ram_rdata : '0;
            r_m_status <= r_status;
            r_m_occ    <= count_wide[deq_pkg::OCC_W-1:0];
        end
    end

    assign o_m_tvalid  = r_m_tvalid;
    assign o_data      = r_m_data;
    assign o_status    = r_m_status;
    assign o_occupancy = r_m_occ;

    deq_ram #(
        .WIDTH (deq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_value),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // The count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("deque count exceeds depth");

    // The front pointer always names a slot of the ring.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front < AW'(DEPTH - 1) || r_front == AW'(DEPTH - 1))
        else $error("front pointer outside ring");

    // A rejected operation leaves the ring state untouched.
    a_reject_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && n_status != deq_pkg::ST_OK |=> $stable(r_count) && $stable(r_front))
        else $error("rejected operation changed ring state");

    // The store is never read and written in the same cycle.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store read and write collide");
`endif

endmodule

// ===== hw/rtl/double_ended_queue_indexed_top.sv =====
// Indexed double-ended queue of signed 32-bit words kept as a ring.
// Top level: joins deq_ctrl, deq_dp (with its deq_ram store); uses deq_pkg.
//
// Usage: each slave word asks for one operation (push front, push back,
// pop front, pop back, read at position, write at position). Every word
// gives exactly one master word with the popped or read value (zero
// otherwise), a status and the occupancy after the operation.
// A word is taken in the idle state, executed in the next cycle against
// the single-port store, and placed in the output register by the emit
// step once that register is free; the controller steps through accept,
// execute and emit around the store's registered read, and master tvalid
// rises as the word is placed in the output register.
// A new word is accepted while a result still waits in the output
// register; a stalled receiver holds the output word stable and stops
// the block only when the next result needs the output register.
// Reset (synchronous, active low) empties the queue and drops any
// pending result; store contents stay undefined until written.
module double_ended_queue_indexed_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]   i_s_tdata,  // value[31:0], position[39:32]
    input  logic [deq_pkg::S_TUSER_W-1:0]   i_s_tuser,  // op[2:0], zero pad above
    // Master stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]   o_m_tdata,  // data[31:0], occupancy[40:32]
    output logic [deq_pkg::M_TUSER_W-1:0]   o_m_tuser   // status[1:0], zero pad above
);

    deq_pkg::t_cmd cmd;
    deq_pkg::t_sts sts;

    logic [deq_pkg::VALUE_W-1:0] out_data;
    logic [deq_pkg::STAT_W-1:0]  out_status;
    logic [deq_pkg::OCC_W-1:0]   out_occ;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_s_tuser[deq_pkg::OP_W-1:0]),
        .i_value     (i_s_tdata[deq_pkg::VALUE_W-1:0]),
        .i_position  (i_s_tdata[deq_pkg::VALUE_W +: deq_pkg::POS_W]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_data      (out_data),
        .o_status    (out_status),
        .o_occupancy (out_occ)
    );

    // Pack the result fields, lowest field first, zero padded.
    assign o_m_tdata = {{(deq_pkg::M_TDATA_W - deq_pkg::VALUE_W - deq_pkg::OCC_W){1'b0}},
                        out_occ, out_data};
    assign o_m_tuser = {{(deq_pkg::M_TUSER_W - deq_pkg::STAT_W){1'b0}}, out_status};

endmodule
